FILE: rtl/core/ctwl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctwl_pkg
// Shared types and codes for the connection table wildcard lookup.
// ----------------------------------------------------------------------------
package ctwl_pkg;

  // widest slot number and age for the supported table depth
  localparam int unsigned IdxW = 10;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_EXACT  = 2'd2;
  localparam logic [1:0] MODE_BEST   = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_FREE = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  // request held for the whole operation
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] local_addr;
    logic [15:0] local_port;
    logic [31:0] foreign_addr;
    logic [15:0] foreign_port;
    logic [5:0]  slot_index;
    logic        allow_wildcard;
  } req_t;

  // running result passed from cell to cell
  typedef struct packed {
    logic            vld;
    logic            found;
    logic [IdxW-1:0] slot;
    logic [1:0]      wc;
    logic [IdxW-1:0] age;
    logic            free_found;
    logic [IdxW-1:0] free_slot;
    logic            tgt_valid;
    logic [IdxW-1:0] tgt_age;
  } token_t;

  // table update issued when the result is handed out
  typedef struct packed {
    logic            ins;
    logic            rem;
    logic [IdxW-1:0] slot;
    logic [IdxW-1:0] gone_age;
  } commit_t;

endpackage

FILE: rtl/core/ctwl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctwl_cell
// One table entry: compares against the request and updates the token.
// ----------------------------------------------------------------------------
module ctwl_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctwl_pkg::req_t    req_i,
  input  ctwl_pkg::commit_t commit_i,
  input  ctwl_pkg::token_t  tok_i,
  output ctwl_pkg::token_t  tok_o
);
  import ctwl_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Idx);

  logic            valid_q;
  logic [IdxW-1:0] age_q;
  logic [31:0]     la_q, fa_q;
  logic [15:0]     lp_q, fp_q;
  token_t          tok_d, tok_q;
  logic            cand;
  logic [1:0]      wc;
  logic            exact_hit, best_ok, lw, fw, better;

  // match and wildcard cost for this entry
  always_comb begin
    exact_hit = (la_q == req_i.local_addr) && (lp_q == req_i.local_port) &&
                (fa_q == req_i.foreign_addr) && (fp_q == req_i.foreign_port);
    best_ok = (lp_q == req_i.local_port);
    lw = 1'b0;
    fw = 1'b0;
    if (la_q != 32'd0) begin
      if (req_i.local_addr == 32'd0) lw = 1'b1;
      else if (la_q != req_i.local_addr) best_ok = 1'b0;
    end else if (req_i.local_addr != 32'd0) begin
      lw = 1'b1;
    end
    if (fa_q != 32'd0) begin
      if (req_i.foreign_addr == 32'd0) fw = 1'b1;
      else if (fa_q != req_i.foreign_addr || fp_q != req_i.foreign_port) best_ok = 1'b0;
    end else if (req_i.foreign_addr != 32'd0) begin
      fw = 1'b1;
    end
    if (req_i.mode == MODE_EXACT) begin
      wc   = 2'd0;
      cand = valid_q && exact_hit;
    end else begin
      wc   = {1'b0, lw} + {1'b0, fw};
      cand = valid_q && best_ok && (req_i.mode == MODE_BEST) &&
             (wc == 2'd0 || req_i.allow_wildcard);
    end
  end

  // fold this entry into the running token
  always_comb begin
    tok_d  = tok_i;
    better = cand && (!tok_i.found || wc < tok_i.wc ||
                      (wc == tok_i.wc && age_q < tok_i.age));
    if (better) begin
      tok_d.found = 1'b1;
      tok_d.slot  = MyIdx;
      tok_d.wc    = wc;
      tok_d.age   = age_q;
    end
    if (!tok_i.free_found && !valid_q) begin
      tok_d.free_found = 1'b1;
      tok_d.free_slot  = MyIdx;
    end
    if (MyIdx == IdxW'(req_i.slot_index)) begin
      tok_d.tgt_valid = valid_q;
      tok_d.tgt_age   = age_q;
    end
  end

  // token register towards the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

  // entry state and age bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= '0;
    end else if (commit_i.ins) begin
      if (commit_i.slot == MyIdx) begin
        valid_q <= 1'b1;
        age_q   <= '0;
      end else if (valid_q) begin
        age_q <= age_q + 1'b1;
      end
    end else if (commit_i.rem) begin
      if (commit_i.slot == MyIdx) begin
        valid_q <= 1'b0;
      end else if (valid_q && age_q > commit_i.gone_age) begin
        age_q <= age_q - 1'b1;
      end
    end
  end

  // tuple payload
  always_ff @(posedge clk_i) begin
    if (commit_i.ins && commit_i.slot == MyIdx) begin
      la_q <= req_i.local_addr;
      lp_q <= req_i.local_port;
      fa_q <= req_i.foreign_addr;
      fp_q <= req_i.foreign_port;
    end
  end

endmodule

FILE: rtl/core/connection_table_wildcard_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connection_table_wildcard_lookup
// Connection table with insert, remove, exact and best-match lookup.
// ----------------------------------------------------------------------------
// channel  direction  signals
// in       input      in_valid_i / in_ready_o, request fields
// out      output     out_valid_o / out_ready_i, status_o slot_o wildcard_count_o
//
// for each request the token walks the row of cells,
// one cell per cycle, then the result is registered and the table updated
// a new request is taken once the previous result sits in the output register
// reset clears every entry at once; no clearing pass is needed
// a stalled output holds the finished request in the done state
module connection_table_wildcard_lookup #(
  parameter int unsigned SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] local_addr_i,
  input  logic [15:0] local_port_i,
  input  logic [31:0] foreign_addr_i,
  input  logic [15:0] foreign_port_i,
  input  logic [5:0]  slot_index_i,
  input  logic        allow_wildcard_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [5:0]  slot_o,
  output logic [1:0]  wildcard_count_o
);
  import ctwl_pkg::*;

  state_e   state_q, state_d;
  req_t     req_q;
  logic     start_q;
  token_t   tok [SLOTS+1];
  token_t   res_q;
  commit_t  commit;
  logic     in_xfer, out_load;
  logic     out_valid_q;
  logic [1:0] status_q, wc_q, status_d, wc_d;
  logic [5:0] slot_q, slot_d;

  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_xfer) state_d = S_SCAN;
      S_SCAN:  if (tok[SLOTS].vld) state_d = S_DONE;
      S_DONE:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= in_xfer;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q <= '{mode: mode_i, local_addr: local_addr_i, local_port: local_port_i,
                 foreign_addr: foreign_addr_i, foreign_port: foreign_port_i,
                 slot_index: slot_index_i, allow_wildcard: allow_wildcard_i};
    end
    if (tok[SLOTS].vld) res_q <= tok[SLOTS];
  end

  // row of cells
  assign tok[0] = '{vld: start_q, default: '0};

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    ctwl_cell #(.Idx(k)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .req_i    (req_q),
      .commit_i (commit),
      .tok_i    (tok[k]),
      .tok_o    (tok[k+1])
    );
  end

  // result and table update
  always_comb begin
    commit   = '0;
    status_d = ST_MISS;
    slot_d   = 6'd0;
    wc_d     = 2'd0;
    case (req_q.mode)
      MODE_INSERT: begin
        if (res_q.free_found) begin
          status_d    = ST_OK;
          slot_d      = res_q.free_slot[5:0];
          commit.ins  = out_load;
          commit.slot = res_q.free_slot;
        end else begin
          status_d = ST_FULL;
        end
      end
      MODE_REMOVE: begin
        slot_d = req_q.slot_index;
        if (res_q.tgt_valid) begin
          status_d        = ST_OK;
          commit.rem      = out_load;
          commit.slot     = IdxW'(req_q.slot_index);
          commit.gone_age = res_q.tgt_age;
        end else begin
          status_d = ST_FREE;
        end
      end
      default: begin
        if (res_q.found) begin
          status_d = ST_OK;
          slot_d   = res_q.slot[5:0];
          wc_d     = (req_q.mode == MODE_BEST) ? res_q.wc : 2'd0;
        end
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      wc_q     <= wc_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign slot_o           = slot_q;
  assign wildcard_count_o = wc_q;

  // checks
  a_tail_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[SLOTS].vld |-> state_q == S_SCAN) else $error("token left row outside scan");
  a_start_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == S_SCAN && start_q) else $error("scan did not start");
  a_commit_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit.ins || commit.rem) |-> out_load && !(commit.ins && commit.rem))
    else $error("bad table update");
  a_load_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && state_q == S_IDLE) else $error("result not presented");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Connection table lookup bench: directed and random insert, remove, exact
// and best-match requests, checked against an in-bench table model.
// ----------------------------------------------------------------------------
import ctwl_pkg::*;

// table model and queue of predicted answers
class conn_table_sb;
  localparam int unsigned Depth = 64;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] slot;
    logic [1:0] wc;
  } answer_t;

  bit          used[Depth];
  logic [31:0] la_q[Depth];
  logic [15:0] lp_q[Depth];
  logic [31:0] fa_q[Depth];
  logic [15:0] fp_q[Depth];
  int unsigned rank[Depth];
  answer_t     pending[$];
  int unsigned errors;
  int unsigned checked;

  function int unsigned occupancy();
    int unsigned n;
    n = 0;
    for (int k = 0; k < Depth; k++) if (used[k]) n++;
    return n;
  endfunction

  // wildcards needed by entry k, 3 when it cannot match
  function int unsigned wild_cost(int k, logic [31:0] la, logic [15:0] lp,
                                  logic [31:0] fa, logic [15:0] fp);
    int unsigned wc;
    wc = 0;
    if (lp_q[k] != lp) return 3;
    if (la_q[k] != 0) begin
      if (la == 0) wc++;
      else if (la_q[k] != la) return 3;
    end else if (la != 0) wc++;
    if (fa_q[k] != 0) begin
      if (fa == 0) wc++;
      else if (fa_q[k] != fa || fp_q[k] != fp) return 3;
    end else if (fa != 0) wc++;
    return wc;
  endfunction

  // note an accepted request and predict its answer
  function void note_request(logic [1:0] mode, logic [31:0] la, logic [15:0] lp,
                             logic [31:0] fa, logic [15:0] fp, logic [5:0] si,
                             logic allow);
    answer_t a;
    int      fk, best;
    int unsigned wc, bwc, gone;
    bit      found;
    a = '0;
    if (mode == MODE_INSERT) begin
      fk = -1;
      for (int k = Depth - 1; k >= 0; k--) if (!used[k]) fk = k;
      if (fk < 0) a.status = ST_FULL;
      else begin
        for (int k = 0; k < Depth; k++) if (used[k]) rank[k]++;
        used[fk] = 1; la_q[fk] = la; lp_q[fk] = lp; fa_q[fk] = fa; fp_q[fk] = fp;
        rank[fk] = 0;
        a.status = ST_OK; a.slot = fk[5:0];
      end
    end else if (mode == MODE_REMOVE) begin
      a.slot = si;
      if (!used[si]) a.status = ST_FREE;
      else begin
        gone = rank[si];
        used[si] = 0;
        for (int k = 0; k < Depth; k++) if (used[k] && rank[k] > gone) rank[k]--;
        a.status = ST_OK;
      end
    end else begin
      found = 0; best = 0; bwc = 3;
      for (int k = 0; k < Depth; k++) begin
        if (!used[k]) continue;
        if (mode == MODE_EXACT) begin
          if (la_q[k] != la || lp_q[k] != lp || fa_q[k] != fa || fp_q[k] != fp)
            continue;
          wc = 0;
        end else begin
          wc = wild_cost(k, la, lp, fa, fp);
          if (wc == 3 || (wc != 0 && !allow)) continue;
        end
        if (!found || wc < bwc || (wc == bwc && rank[k] < rank[best])) begin
          found = 1; best = k; bwc = wc;
        end
      end
      if (!found) a.status = ST_MISS;
      else begin
        a.status = ST_OK; a.slot = best[5:0];
        a.wc = (mode == MODE_BEST) ? bwc[1:0] : 2'd0;
      end
    end
    pending.push_back(a);
  endfunction

  // compare one result transfer with the oldest prediction
  function void check_answer(logic [1:0] st, logic [5:0] sl, logic [1:0] wc);
    answer_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result status=%0d slot=%0d wc=%0d",
               $time, st, sl, wc);
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    if (st !== e.status) begin
      $display("%0t: status expected %0d actual %0d", $time, e.status, st); errors++;
    end
    if (sl !== e.slot) begin
      $display("%0t: slot expected %0d actual %0d", $time, e.slot, sl); errors++;
    end
    if (wc !== e.wc) begin
      $display("%0t: wildcard_count expected %0d actual %0d", $time, e.wc, wc);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int unsigned NumRandom = 1600;
  localparam int unsigned CycleLimit = 1000000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [1:0]  mode_i = '0;
  logic [31:0] local_addr_i = '0;
  logic [15:0] local_port_i = '0;
  logic [31:0] foreign_addr_i = '0;
  logic [15:0] foreign_port_i = '0;
  logic [5:0]  slot_index_i = '0;
  logic        allow_wildcard_i = 0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [1:0]  status_o;
  logic [5:0]  slot_o;
  logic [1:0]  wildcard_count_o;

  conn_table_sb table_sb = new();
  bit           calm;
  int unsigned  cycles;
  int unsigned  mode_seen[4];

  // small pools so lookups hit stored tuples
  logic [31:0] addr_pool[4] = '{32'h0a000001, 32'hc0a80101, 32'hffffffff, 32'h00000001};
  logic [15:0] port_pool[3] = '{16'd80, 16'hffff, 16'd0};

  connection_table_wildcard_lookup dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: sample at rising edge, ready changes at falling edge
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i)
      table_sb.check_answer(status_o, slot_o, wildcard_count_o);

  always @(negedge clk_i)
    out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 24);

  // one request transfer, then random idle gap
  task automatic send(logic [1:0] m, logic [31:0] la, logic [15:0] lp,
                      logic [31:0] fa, logic [15:0] fp, logic [5:0] si, logic aw);
    mode_i <= m; local_addr_i <= la; local_port_i <= lp;
    foreign_addr_i <= fa; foreign_port_i <= fp; slot_index_i <= si;
    allow_wildcard_i <= aw; in_valid_i <= 1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    table_sb.note_request(m, la, lp, fa, fp, si, aw);
    mode_seen[m]++;
    @(negedge clk_i);
    if (!calm) begin
      while ($urandom_range(99) < 24) begin
        in_valid_i <= 0;
        @(negedge clk_i);
      end
    end
  endtask

  function automatic logic [31:0] pick_addr();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 3) return 32'h0;
    if (r < 8) return addr_pool[$urandom_range(3)];
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_port();
    if ($urandom_range(9) < 8) return port_pool[$urandom_range(2)];
    return 16'($urandom);
  endfunction

  initial begin
    int unsigned idle;
    logic [1:0]  m;
    calm = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // directed: lookups on empty table, extremes, wildcard ranking, removes
    send(MODE_EXACT, 0, 0, 0, 0, 0, 0);
    send(MODE_BEST, 0, 0, 0, 0, 0, 1);
    send(MODE_REMOVE, 0, 0, 0, 0, 6'd63, 0);
    send(MODE_INSERT, 32'hffffffff, 16'hffff, 32'hffffffff, 16'hffff, 0, 0);
    send(MODE_INSERT, 32'h0, 16'd80, 32'h0, 16'd0, 0, 0);
    send(MODE_INSERT, 32'h0a000001, 16'd80, 32'h0, 16'd0, 0, 0);
    send(MODE_INSERT, 32'h0a000001, 16'd80, 32'hc0a80101, 16'd1234, 0, 0);
    send(MODE_INSERT, 32'h0a000001, 16'd80, 32'hc0a80101, 16'd1234, 0, 0);
    send(MODE_EXACT, 32'h0a000001, 16'd80, 32'hc0a80101, 16'd1234, 0, 0);
    send(MODE_BEST, 32'h0a000001, 16'd80, 32'hc0a80101, 16'd1234, 0, 0);
    send(MODE_BEST, 32'h0a000001, 16'd80, 32'hc0a80101, 16'd9, 0, 0);
    send(MODE_BEST, 32'h0a000001, 16'd80, 32'hc0a80101, 16'd9, 0, 1);
    send(MODE_BEST, 32'h0a000002, 16'd80, 32'h01020304, 16'd9, 0, 1);
    send(MODE_BEST, 32'h0, 16'd80, 32'h0, 16'd0, 0, 1);
    send(MODE_BEST, 32'hffffffff, 16'hffff, 32'hffffffff, 16'h0, 0, 1);
    send(MODE_REMOVE, 0, 0, 0, 0, 6'd3, 0);
    send(MODE_REMOVE, 0, 0, 0, 0, 6'd3, 0);
    send(MODE_BEST, 32'h0a000001, 16'd80, 32'hc0a80101, 16'd1234, 0, 0);
    // fill to full, insert once more, then free the top slot
    for (int k = 0; k < 61; k++)
      send(MODE_INSERT, $urandom, 16'($urandom), $urandom, 16'($urandom), 0, 0);
    send(MODE_INSERT, 1, 2, 3, 4, 0, 0);
    send(MODE_REMOVE, 0, 0, 0, 0, 6'd63, 0);
    send(MODE_INSERT, 0, 16'hffff, 0, 16'hffff, 0, 0);
    for (int k = 0; k < 64; k++) send(MODE_REMOVE, 0, 0, 0, 0, k[5:0], 0);

    // random part, with a stretch free of idling in the middle
    for (int n = 0; n < NumRandom; n++) begin
      calm = (n >= 700 && n < 900);
      m = 2'($urandom_range(3));
      // keep occupancy moving: bias by how full the table is
      if (table_sb.occupancy() > 48 && m == MODE_INSERT && $urandom_range(1))
        m = MODE_REMOVE;
      if (m == MODE_REMOVE && $urandom_range(3) != 0) begin
        idle = $urandom_range(63);
        for (int k = 0; k < 64; k++)
          if (table_sb.used[(idle + k) % 64]) begin
            idle = (idle + k) % 64;
            break;
          end
      end else idle = $urandom_range(63);
      send(m, pick_addr(), pick_port(), pick_addr(), pick_port(), idle[5:0],
           1'($urandom_range(1)));
    end
    calm = 1;
    in_valid_i <= 0;

    idle = 0;
    while (table_sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("covered %0d results: %0d inserts, %0d removes, %0d exact, %0d best match",
             table_sb.checked, mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3]);
    if (table_sb.errors == 0 && table_sb.pending.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/ctwl_pkg.sv
rtl/core/ctwl_cell.sv
rtl/core/connection_table_wildcard_lookup.sv
bench/tb_top.sv
